/* rtl/c16x_pkg.sv */
// ----------------------------------------------------------------------------
// c16x_pkg
// types, opcodes and fault codes of the cpu16 execute block
// ----------------------------------------------------------------------------
package c16x_pkg;

	localparam logic [1:0] OP_ROM = 2'd0;
	localparam logic [1:0] OP_RAM = 2'd1;

	localparam logic [3:0] OPC_INVALID = 4'h0;
	localparam logic [3:0] OPC_MOV     = 4'h1;
	localparam logic [3:0] OPC_ALU     = 4'h2;
	localparam logic [3:0] OPC_CMP     = 4'h3;
	localparam logic [3:0] OPC_BRA     = 4'h4;
	localparam logic [3:0] OPC_BRB     = 4'h5;
	localparam logic [3:0] OPC_IN      = 4'h6;
	localparam logic [3:0] OPC_OUT     = 4'h7;
	localparam logic [3:0] OPC_LDW     = 4'h8;
	localparam logic [3:0] OPC_STW     = 4'h9;
	localparam logic [3:0] OPC_CALL    = 4'hA;
	localparam logic [3:0] OPC_RET     = 4'hB;
	localparam logic [3:0] OPC_PUSH    = 4'hC;
	localparam logic [3:0] OPC_PULL    = 4'hD;
	localparam logic [3:0] OPC_RES0    = 4'hE;
	localparam logic [3:0] OPC_RES1    = 4'hF;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_AND = 3'd2;
	localparam logic [2:0] FN_OR  = 3'd3;
	localparam logic [2:0] FN_XOR = 3'd4;
	localparam logic [2:0] FN_NOT = 3'd5;
	localparam logic [2:0] FN_SHL = 3'd6;
	localparam logic [2:0] FN_SHR = 3'd7;

	localparam logic [2:0] FLT_NONE     = 3'd0;
	localparam logic [2:0] FLT_INVALID  = 3'd1;
	localparam logic [2:0] FLT_RESERVED = 3'd2;
	localparam logic [2:0] FLT_IO       = 3'd3;
	localparam logic [2:0] FLT_R0       = 3'd4;
	localparam logic [2:0] FLT_STACK    = 3'd5;

	localparam logic [15:0] RAM_BASE = 16'h8000;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  opcode;
		logic [2:0]  functor;
		logic [3:0]  dest_index;
		logic [3:0]  source_index;
		logic        use_immediate;
		logic [15:0] immediate_word;
		logic [15:0] preload_address;
		logic [15:0] preload_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] next_ip;
		logic        carry_flag;
		logic        zero_flag;
		logic        sign_flag;
		logic        overflow_flag;
		logic        video_write;
		logic [15:0] video_index;
		logic [15:0] video_data;
		logic [2:0]  fault;
	} out_item_t;

	// flags: c z s v
	typedef struct packed {
		logic v;
		logic s;
		logic z;
		logic c;
	} flags_t;

endpackage

/* rtl/c16x_stream_if.sv */
// ----------------------------------------------------------------------------
// c16x_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface c16x_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/c16x_ram.sv */
// ----------------------------------------------------------------------------
// c16x_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module c16x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/c16x_alu.sv */
// ----------------------------------------------------------------------------
// c16x_alu
// alu, compare and test with status flag generation
// ----------------------------------------------------------------------------
module c16x_alu
	import c16x_pkg::*;
(
	input  logic [3:0]  opcode,
	input  logic [2:0]  functor,
	input  logic [15:0] d,
	input  logic [15:0] val,
	output logic [15:0] result,
	output flags_t      flags
);
	logic [16:0] sum;
	logic [16:0] dif;
	logic [15:0] r;
	logic        arith;
	logic        is_sub;

	always_comb begin
		sum = {1'b0, d} + {1'b0, val};
		dif = {1'b0, d} - {1'b0, val};
		arith = 1'b0;
		is_sub = 1'b0;
		if (opcode == OPC_CMP) begin
			if (functor == FN_SUB) begin
				r = dif[15:0];
				arith = 1'b1;
				is_sub = 1'b1;
			end else begin
				r = d & val;
			end
		end else begin
			case (functor)
				FN_ADD: begin
					r = sum[15:0];
					arith = 1'b1;
				end
				FN_SUB: begin
					r = dif[15:0];
					arith = 1'b1;
					is_sub = 1'b1;
				end
				FN_AND: r = d & val;
				FN_OR:  r = d | val;
				FN_XOR: r = d ^ val;
				FN_NOT: r = ~d;
				FN_SHL: r = d << val[3:0];
				default: r = d >> val[3:0];
			endcase
		end
		result = r;
		flags.z = (r == 16'd0);
		flags.s = r[15];
		flags.c = arith & (is_sub ? dif[16] : sum[16]);
		flags.v = arith & (is_sub ? ((d[15] ^ val[15]) & (d[15] ^ r[15]))
			: ((d[15] ^ r[15]) & (val[15] ^ r[15])));
	end
endmodule

/* rtl/cpu16_instruction_execute.sv */
// ----------------------------------------------------------------------------
// cpu16_instruction_execute
// execute stage of a small 16-bit cpu with register file, rom and ram
// ----------------------------------------------------------------------------
// in_ch carries preload and execute transactions, out_ch one result per
// transaction. on acceptance the memory address operand is formed and the
// memory word is read from synchronous rams; the transaction then waits in
// the read stage, where the register file operands are read from flip-flops,
// and is retired from there: flags, pointer, register and memory are written
// back and the result is loaded into the output register. throughput is one
// transaction per cycle while out_ch is not stalled, since the register and
// stack pointer values and a memory word written by the retiring transaction
// are forwarded to the one accepted at the same edge. a load reads its
// address only after the operand is known, so the memory read uses the
// operand read cycle: ldw, pull and ret read memory through an address
// formed from the immediate, register or stack pointer read in the previous
// retire, forwarded combinationally. reset clears the register file, flags
// and pointer; rom and ram contents are undefined until preloaded. while
// out_ch is stalled a new transaction is taken in only if the read stage is
// empty; it waits there until the output register frees.
// ----------------------------------------------------------------------------
module cpu16_instruction_execute
	import c16x_pkg::*;
#(
	parameter int RAM_WORDS   = 4096,
	parameter int ROM_WORDS   = 4096,
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input logic           clk,
	input logic           arst_n,
	c16x_stream_if.sink   in_ch,
	c16x_stream_if.source out_ch
);
	localparam int RAW = $clog2(RAM_WORDS);
	localparam int ROW = $clog2(ROM_WORDS);

	// register file in flip-flops: 16 entries, read at acceptance and in the execute stage
	logic [15:0] regs_q [16];
	logic [15:0] ip_q;
	flags_t      flags_q;

	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   out_q;
	logic        out_valid_q;

	in_item_t    it;
	logic        retire;

	assign it = in_ch.payload;
	assign retire = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || retire;

	// operand read at acceptance for the memory address
	logic [15:0] val_a;
	logic [15:0] sp_a;
	logic [15:0] maddr_a;
	logic        is_stk_a;

	// forwarding from the retiring transaction
	logic        rf_we;
	logic [3:0]  rf_wa;
	logic [15:0] rf_wd;
	logic        sp_we;
	logic [15:0] sp_wd;

	function automatic logic [15:0] rd_fwd(input logic [3:0] a, input logic we1,
		input logic [3:0] wa1, input logic [15:0] wd1, input logic we2,
		input logic [15:0] wd2, input logic [15:0] q);
		logic [15:0] v;
		v = q;
		if (we2 && a == 4'd2) v = wd2;
		if (we1 && a == wa1) v = wd1;
		return v;
	endfunction

	always_comb begin
		val_a = it.use_immediate ? it.immediate_word
			: rd_fwd(it.source_index, rf_we & retire, rf_wa, rf_wd, sp_we & retire, sp_wd,
				regs_q[it.source_index]);
		sp_a = rd_fwd(4'd2, rf_we & retire, rf_wa, rf_wd, sp_we & retire, sp_wd, regs_q[2]);
		is_stk_a = (it.opcode == OPC_RET) || (it.opcode == OPC_PULL);
		maddr_a = is_stk_a ? sp_a : val_a;
	end

	// memories
	logic            rom_we;
	logic [ROW-1:0]  rom_wa;
	logic [15:0]     rom_rd;
	logic            ram_we;
	logic [RAW-1:0]  ram_wa;
	logic [15:0]     ram_wd;
	logic [15:0]     ram_rd;
	logic            accept;

	assign accept = in_ch.valid && in_ch.ready;

	c16x_ram #(.WIDTH(16), .DEPTH(ROM_WORDS)) u_rom (
		.clk   (clk),
		.we    (rom_we),
		.waddr (rom_wa),
		.wdata (item_s1.preload_data),
		.raddr (maddr_a[ROW-1:0]),
		.rdata (rom_rd)
	);

	c16x_ram #(.WIDTH(16), .DEPTH(RAM_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (maddr_a[RAW-1:0]),
		.rdata (ram_rd)
	);

	// memory read only valid when read at acceptance; while held, the word captured then is used
	logic [15:0] rom_hold_q;
	logic [15:0] ram_hold_q;
	logic        fresh_q;
	logic [15:0] rom_word;
	logic [15:0] ram_word;

	// word written by the retiring transaction at the read edge
	logic        rom_fwd_q;
	logic        ram_fwd_q;
	logic [15:0] rom_fwd_d_q;
	logic [15:0] ram_fwd_d_q;
	logic [15:0] rom_now;
	logic [15:0] ram_now;

	assign rom_now = rom_fwd_q ? rom_fwd_d_q : rom_rd;
	assign ram_now = ram_fwd_q ? ram_fwd_d_q : ram_rd;
	assign rom_word = fresh_q ? rom_now : rom_hold_q;
	assign ram_word = fresh_q ? ram_now : ram_hold_q;

	// execute stage
	logic [15:0] val;
	logic [15:0] d;
	logic [15:0] sp;
	logic [15:0] nip;
	logic [15:0] sp_dn;
	logic [15:0] alu_r;
	flags_t      alu_f;
	logic        push_ok;
	logic        pull_ok;
	logic        writes;
	logic [2:0]  flt;
	logic        taken;
	logic        is_exec;
	logic [15:0] mword;
	logic [7:0]  vrow;
	logic [7:0]  vcol;
	out_item_t   res;
	flags_t      new_flags;
	logic [15:0] new_ip;

	c16x_alu u_alu (
		.opcode  (item_s1.opcode),
		.functor (item_s1.functor),
		.d       (d),
		.val     (val),
		.result  (alu_r),
		.flags   (alu_f)
	);

	always_comb begin
		is_exec = !(item_s1.operation == OP_ROM || item_s1.operation == OP_RAM);
		val = item_s1.use_immediate ? item_s1.immediate_word : regs_q[item_s1.source_index];
		d = regs_q[item_s1.dest_index];
		sp = regs_q[2];
		sp_dn = sp - 16'd1;
		nip = ip_q + (item_s1.use_immediate ? 16'd2 : 16'd1);
		push_ok = (sp > RAM_BASE) || (sp == 16'd0);
		pull_ok = (sp >= RAM_BASE);
		writes = item_s1.opcode inside {OPC_MOV, OPC_LDW, OPC_PULL, OPC_ALU}
			|| (item_s1.opcode == OPC_CMP && (item_s1.functor == FN_SUB
			|| item_s1.functor == FN_AND));
		flt = FLT_NONE;
		if (item_s1.opcode == OPC_INVALID) flt = FLT_INVALID;
		else if (item_s1.opcode inside {OPC_RES0, OPC_RES1}
			|| (item_s1.opcode == OPC_CMP && item_s1.functor != FN_SUB
			&& item_s1.functor != FN_AND)
			|| (item_s1.opcode == OPC_RET && item_s1.functor > 3'd1)) flt = FLT_RESERVED;
		else if (item_s1.opcode inside {OPC_IN, OPC_OUT}) flt = FLT_IO;
		else if (writes && item_s1.dest_index == 4'd0) flt = FLT_R0;
		else if (item_s1.opcode inside {OPC_CALL, OPC_PUSH} && !push_ok) flt = FLT_STACK;
		else if (item_s1.opcode inside {OPC_PULL, OPC_RET} && !pull_ok) flt = FLT_STACK;
		if (!is_exec) flt = FLT_NONE;

		case (item_s1.functor)
			3'd0: taken = (item_s1.opcode == OPC_BRA) ? 1'b1 : (regs_q[0][3:0] != 4'd0);
			3'd1: taken = (item_s1.opcode == OPC_BRA) ? flags_q.z : flags_q.s;
			3'd2: taken = (item_s1.opcode == OPC_BRA) ? !flags_q.z : !flags_q.s;
			3'd3: taken = (item_s1.opcode == OPC_BRA) ? (flags_q.s == flags_q.v) : !flags_q.c;
			3'd4: taken = (item_s1.opcode == OPC_BRA) ? (flags_q.z || flags_q.s != flags_q.v)
				: (flags_q.c || flags_q.z);
			3'd5: taken = (item_s1.opcode == OPC_BRA) ? (!flags_q.z && flags_q.s == flags_q.v)
				: (!flags_q.c && !flags_q.z);
			3'd6: taken = (item_s1.opcode == OPC_BRA) ? (flags_q.s != flags_q.v) : flags_q.c;
			default: taken = (item_s1.opcode == OPC_BRA) ? flags_q.v : !flags_q.v;
		endcase

		mword = (val < RAM_BASE) ? rom_word : ram_word;
		vrow = val[15:8];
		vcol = val[7:0];

		rf_we = 1'b0;
		rf_wa = item_s1.dest_index;
		rf_wd = 16'd0;
		sp_we = 1'b0;
		sp_wd = 16'd0;
		ram_we = 1'b0;
		ram_wa = val[RAW-1:0];
		ram_wd = d;
		rom_we = 1'b0;
		rom_wa = item_s1.preload_address[ROW-1:0];
		new_flags = flags_q;
		new_ip = nip;
		res = '0;

		if (item_s1.operation == OP_ROM) begin
			rom_we = 1'b1;
		end else if (item_s1.operation == OP_RAM) begin
			ram_we = 1'b1;
			ram_wa = item_s1.preload_address[RAW-1:0];
			ram_wd = item_s1.preload_data;
		end else if (flt == FLT_NONE) begin
			case (item_s1.opcode)
				OPC_MOV: begin
					rf_we = 1'b1;
					rf_wd = val;
				end
				OPC_LDW: begin
					rf_we = 1'b1;
					rf_wd = mword;
				end
				OPC_STW: begin
					if (val < RAM_BASE) begin
						if ({8'd0, vcol} < 16'(SCREEN_COLS) && {8'd0, vrow} < 16'(SCREEN_ROWS)) begin
							res.video_write = 1'b1;
							res.video_index = 16'(32'(vrow) * 32'(SCREEN_COLS) + 32'(vcol));
							res.video_data = d;
						end
					end else begin
						ram_we = 1'b1;
					end
				end
				OPC_CALL, OPC_PUSH: begin
					sp_we = 1'b1;
					sp_wd = sp_dn;
					ram_we = 1'b1;
					ram_wa = sp_dn[RAW-1:0];
					ram_wd = (item_s1.opcode == OPC_CALL) ? nip : val;
					if (item_s1.opcode == OPC_CALL) new_ip = val;
				end
				OPC_RET, OPC_PULL: begin
					sp_we = 1'b1;
					sp_wd = sp + 16'd1;
					if (item_s1.opcode == OPC_RET) begin
						new_ip = ram_word;
					end else begin
						rf_we = 1'b1;
						rf_wd = ram_word;
					end
				end
				OPC_ALU: begin
					rf_we = 1'b1;
					rf_wd = alu_r;
					new_flags = alu_f;
				end
				OPC_CMP: begin
					new_flags = alu_f;
				end
				default: begin
					if (taken) new_ip = val;
				end
			endcase
		end
		if (!is_exec || flt != FLT_NONE) new_ip = ip_q;
		res.next_ip = new_ip;
		res.carry_flag = new_flags.c;
		res.zero_flag = new_flags.z;
		res.sign_flag = new_flags.s;
		res.overflow_flag = new_flags.v;
		res.fault = flt;
		if (!retire) begin
			rf_we = 1'b0;
			sp_we = 1'b0;
			ram_we = 1'b0;
			rom_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			ip_q <= 16'd0;
			flags_q <= '0;
			fresh_q <= 1'b0;
			for (int i = 0; i < 16; i++) regs_q[i] <= 16'd0;
		end else begin
			fresh_q <= accept;
			if (accept) valid_s1 <= 1'b1;
			else if (retire) valid_s1 <= 1'b0;
			if (retire) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (retire) begin
				ip_q <= new_ip;
				flags_q <= new_flags;
				if (sp_we) regs_q[2] <= sp_wd;
				if (rf_we) regs_q[rf_wa] <= rf_wd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= it;
		rom_fwd_q <= rom_we && (rom_wa == maddr_a[ROW-1:0]);
		rom_fwd_d_q <= item_s1.preload_data;
		ram_fwd_q <= ram_we && (ram_wa == maddr_a[RAW-1:0]);
		ram_fwd_d_q <= ram_wd;
		if (fresh_q) begin
			rom_hold_q <= rom_now;
			ram_hold_q <= ram_now;
		end
		if (retire) out_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;
endmodule

/* rtl/c16x_checker.sv */
// ----------------------------------------------------------------------------
// c16x_checker
// port-level checks of the cpu16 execute block
// ----------------------------------------------------------------------------
module c16x_checker
	import c16x_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_payload
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result dropped while stalled");

	a_fault_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload.fault <= FLT_STACK)
		else $error("fault code out of range");

	a_fault_no_video: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.fault != FLT_NONE |-> !out_payload.video_write)
		else $error("faulting transaction wrote video");

	a_no_video_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_payload.video_write |->
		out_payload.video_index == 16'd0 && out_payload.video_data == 16'd0)
		else $error("video fields set without a write");

	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("no result after transaction");
endmodule

bind cpu16_instruction_execute c16x_checker u_c16x_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);
